FILE: rtl/fcgi_rd_pkg.sv
// Shared types and constants for the FastCGI response record deframer.
// No dependencies; imported by fastcgi_response_record_deframer_top.
package fcgi_rd_pkg;

    localparam int unsigned HDR_LEN = 8;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_LEN);

    // Header byte positions
    localparam logic [HDR_IDX_W-1:0] HDR_TYPE   = HDR_IDX_W'(1);
    localparam logic [HDR_IDX_W-1:0] HDR_ID_HI  = HDR_IDX_W'(2);
    localparam logic [HDR_IDX_W-1:0] HDR_ID_LO  = HDR_IDX_W'(3);
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI = HDR_IDX_W'(4);
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO = HDR_IDX_W'(5);
    localparam logic [HDR_IDX_W-1:0] HDR_PAD    = HDR_IDX_W'(6);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST   = HDR_IDX_W'(HDR_LEN - 1);

    // Record types
    localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
    localparam logic [7:0] TYPE_STDOUT      = 8'd6;
    localparam logic [7:0] TYPE_STDERR      = 8'd7;

    // Result kinds
    localparam logic [1:0] KIND_STDOUT = 2'd0;
    localparam logic [1:0] KIND_STDERR = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [15:0] ACCEPT_ID_RESET = 16'd1;

    typedef enum logic [2:0] {
        PH_HDR  = 3'b001,
        PH_CONT = 3'b010,
        PH_PAD  = 3'b100
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [1:0] kind;
    } t_result;

endpackage

FILE: rtl/fastcgi_response_record_deframer_top.sv
// FastCGI response record deframer: parses record headers, forwards matching
// STDOUT/STDERR content bytes and emits an end marker. Uses fcgi_rd_pkg.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+--------------------------------
//   s       | in  | s_tvalid / s_tready        | s_tdata[7:0] = in_byte
//   m       | out | m_tvalid / m_tready        | m_tdata[7:0] = out_byte,
//           |     |                            | m_tuser[1:0] = kind
//   cfg     | in  | cfg_valid / cfg_ready      | cfg_data[15:0] = accepted record id
//
// One byte per cycle while s_tready is high: the parser updates its
// header/counter state and registers any result in the cycle the byte is accepted.
// A two-entry output stage (result register plus skid register) keeps
// s_tready registered; input stalls only when both entries are full.
// Reset is synchronous, active low; the accepted record id resets to 1.
// cfg_ready is always high.
module fastcgi_response_record_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] accepted record id
);
    import fcgi_rd_pkg::*;

    logic [15:0]          r_accept_id;
    t_phase               r_phase, n_phase;
    logic [HDR_IDX_W-1:0] r_hdr_idx, n_hdr_idx;
    logic [7:0]           r_type, n_type;
    logic [7:0]           r_id_hi, n_id_hi;
    logic                 r_match, n_match;
    logic [15:0]          r_content_left, n_content_left;
    logic [7:0]           r_padding_left, n_padding_left;
    t_result              r_out, r_skid;
    t_result              res;

    logic        s_fire;
    logic        m_pop;
    logic [15:0] content_dec;
    logic        is_stream;

    assign cfg_ready = 1'b1;
    assign s_tready  = !r_skid.valid;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = r_out.valid;
    assign m_tdata   = r_out.data;
    assign m_tuser   = r_out.kind;
    assign m_pop     = r_out.valid && m_tready;

    assign content_dec = r_content_left - 16'd1;
    assign is_stream   = r_type inside {TYPE_STDOUT, TYPE_STDERR};

    always_comb begin
        n_phase        = r_phase;
        n_hdr_idx      = r_hdr_idx;
        n_type         = r_type;
        n_id_hi        = r_id_hi;
        n_match        = r_match;
        n_content_left = r_content_left;
        n_padding_left = r_padding_left;
        res            = '{valid: 1'b0, data: 8'd0, kind: KIND_END};

        case (r_phase)
            PH_CONT: begin
                if (r_match && is_stream) begin
                    res = '{valid: 1'b1, data: s_tdata,
                            kind: (r_type == TYPE_STDOUT) ? KIND_STDOUT : KIND_STDERR};
                end
                n_content_left = content_dec;
                if (content_dec == 16'd0) begin
                    if (r_padding_left != 8'd0) begin
                        n_phase = PH_PAD;
                    end else begin
                        n_phase   = PH_HDR;
                        n_hdr_idx = '0;
                        if (r_match && r_type == TYPE_END_REQUEST) begin
                            res.valid = 1'b1;
                        end
                    end
                end
            end
            PH_PAD: begin
                n_padding_left = r_padding_left - 8'd1;
                if (r_padding_left == 8'd1) begin
                    n_phase   = PH_HDR;
                    n_hdr_idx = '0;
                    res.valid = r_match && (r_type == TYPE_END_REQUEST);
                end
            end
            default: begin
                n_phase = PH_HDR;
                case (r_hdr_idx)
                    HDR_TYPE:   n_type = s_tdata;
                    HDR_ID_HI:  n_id_hi = s_tdata;
                    HDR_ID_LO:  n_match = ({r_id_hi, s_tdata} == r_accept_id);
                    HDR_LEN_HI: n_content_left = {8'd0, s_tdata};
                    HDR_LEN_LO: n_content_left = {r_content_left[7:0], s_tdata};
                    HDR_PAD:    n_padding_left = s_tdata;
                    default: ;
                endcase
                if (r_hdr_idx == HDR_LAST) begin
                    n_hdr_idx = '0;
                    if (r_content_left != 16'd0) begin
                        n_phase = PH_CONT;
                    end else if (r_padding_left != 8'd0) begin
                        n_phase = PH_PAD;
                    end else begin
                        res.valid = r_match && (r_type == TYPE_END_REQUEST);
                    end
                end else begin
                    n_hdr_idx = r_hdr_idx + HDR_IDX_W'(1);
                end
            end
        endcase

        if (!s_fire) begin
            res.valid = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_id    <= ACCEPT_ID_RESET;
            r_phase        <= PH_HDR;
            r_hdr_idx      <= '0;
            r_type         <= 8'd0;
            r_id_hi        <= 8'd0;
            r_match        <= 1'b0;
            r_content_left <= 16'd0;
            r_padding_left <= 8'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                r_accept_id <= cfg_data;
            end
            if (s_fire) begin
                r_phase        <= n_phase;
                r_hdr_idx      <= n_hdr_idx;
                r_type         <= n_type;
                r_id_hi        <= n_id_hi;
                r_match        <= n_match;
                r_content_left <= n_content_left;
                r_padding_left <= n_padding_left;
            end
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (m_pop) begin
            if (r_skid.valid) begin
                // advance skid entry, park any new result behind it
                r_out  <= r_skid;
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end else if (!r_out.valid) begin
            r_out <= res;
        end else if (res.valid) begin
            r_skid <= res;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |-> r_out.valid)
        else $error("skid entry valid with empty output register");

    a_content_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CONT) |-> (r_content_left != 16'd0))
        else $error("content phase with zero content count");

    a_padding_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAD) |-> (r_padding_left != 8'd0))
        else $error("padding phase with zero padding count");

    a_hdr_idx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr_idx != '0) |-> (r_phase == PH_HDR))
        else $error("header index moved outside header phase");

    a_end_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == KIND_END) |-> (m_tdata == 8'd0))
        else $error("end marker carries nonzero data");

    a_no_result_without_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out.valid && !s_fire) |=> !r_out.valid)
        else $error("result appeared without an input beat");
`endif

endmodule

FILE: tb/fcgi_rd_scoreboard.sv
// Scoreboard for the FastCGI response deframer: follows the input byte stream,
// predicts the payload and end-marker beats, and compares the output channel.
// Depends on fcgi_rd_pkg for record types, header positions, kinds and phases.
module fcgi_rd_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          o_fail_count,
    output int          o_payload_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import fcgi_rd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } t_payload;

    t_payload    payload_due[$];
    t_payload    oldest;
    int          fail_count = 0;

    // Parser copy
    logic [15:0] want_id;
    t_phase      ph;
    logic [2:0]  hdr_idx;
    logic [7:0]  rec_type;
    logic [15:0] id_accum;
    logic [15:0] content_left;
    logic [7:0]  pad_left;
    logic        id_hit;

    assign o_fail_count  = fail_count;
    assign o_payload_due = payload_due.size();

    task automatic close_record();
        ph      = PH_HDR;
        hdr_idx = '0;
        if (id_hit && rec_type == TYPE_END_REQUEST) begin
            payload_due.push_back('{data: 8'h00, kind: KIND_END});
        end
    endtask

    task automatic parse_stream_byte(input logic [7:0] b);
        logic passes;
        if (ph == PH_CONT) begin
            passes = id_hit && (rec_type == TYPE_STDOUT || rec_type == TYPE_STDERR);
            if (passes) begin
                payload_due.push_back('{data: b,
                    kind: (rec_type == TYPE_STDOUT) ? KIND_STDOUT : KIND_STDERR});
            end
            content_left = content_left - 16'd1;
            if (content_left == 16'd0) begin
                if (pad_left != 8'd0) begin
                    ph = PH_PAD;
                end else begin
                    close_record();
                end
            end
        end else if (ph == PH_PAD) begin
            pad_left = pad_left - 8'd1;
            if (pad_left == 8'd0) begin
                close_record();
            end
        end else begin
            ph = PH_HDR;
            case (hdr_idx)
                HDR_TYPE:   rec_type = b;
                HDR_ID_HI:  id_accum = {8'h00, b};
                HDR_ID_LO: begin
                    // id is judged once, against the register value of this beat
                    id_accum = {id_accum[7:0], b};
                    id_hit   = (id_accum == want_id);
                end
                HDR_LEN_HI: content_left = {8'h00, b};
                HDR_LEN_LO: content_left = {content_left[7:0], b};
                HDR_PAD:    pad_left = b;
                default: ;
            endcase
            if (hdr_idx == HDR_LAST) begin
                hdr_idx = '0;
                if (content_left != 16'd0) begin
                    ph = PH_CONT;
                end else if (pad_left != 8'd0) begin
                    ph = PH_PAD;
                end else begin
                    close_record();
                end
            end else begin
                hdr_idx = hdr_idx + 3'd1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            want_id      = ACCEPT_ID_RESET;
            ph           = PH_HDR;
            hdr_idx      = '0;
            rec_type     = '0;
            id_accum     = '0;
            content_left = '0;
            pad_left     = '0;
            id_hit       = 1'b0;
            payload_due.delete();
        end else begin
            // compare before adding this edge's prediction
            if (m_tvalid && m_tready) begin
                if (payload_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected beat, expected none actual data %h kind %0d",
                             $time, m_tdata, m_tuser);
                end else begin
                    oldest = payload_due.pop_front();
                    if (m_tdata !== oldest.data) begin
                        fail_count++;
                        $display("%0t: data mismatch, expected %h actual %h",
                                 $time, oldest.data, m_tdata);
                    end
                    if (m_tuser !== oldest.kind) begin
                        fail_count++;
                        $display("%0t: kind mismatch, expected %0d actual %0d",
                                 $time, oldest.kind, m_tuser);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                want_id = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                parse_stream_byte(s_tdata);
            end
        end
    end

endmodule

FILE: tb/fastcgi_response_record_deframer_top_tb.sv
// Top of the deframer testbench: clock, reset, record stimulus, output stalls
// and the verdict. Instantiates fastcgi_response_record_deframer_top and
// fcgi_rd_scoreboard; uses fcgi_rd_pkg for record type codes.
module fastcgi_response_record_deframer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcgi_rd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 60;
    localparam int NUM_PHASES    = 5;
    localparam int CYCLE_LIMIT   = 400000;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = 16'h0000;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_ready;

    int          fail_count;
    int          payload_due;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          stall_left  = 0;
    bit          gaps_on     = 1'b1;
    bit          stalls_on   = 1'b1;
    logic [15:0] current_id  = ACCEPT_ID_RESET;

    // STDOUT with two bytes and one pad, one-byte STDERR, empty END_REQUEST
    logic [7:0] opening_bytes [28] = '{
        8'h01, TYPE_STDOUT, 8'h00, 8'h01, 8'h00, 8'h02, 8'h01, 8'h00,
        8'h00, 8'hFF, 8'hA5,
        8'h01, TYPE_STDERR, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
        8'h5A,
        8'hFF, TYPE_END_REQUEST, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF
    };

    fastcgi_response_record_deframer_top u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    fcgi_rd_scoreboard u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .o_fail_count  (fail_count),
        .o_payload_due (payload_due)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fastcgi_response_record_deframer_top_tb: FAIL");
            $finish;
        end
    end

    // Output side: drop m_tready in random stall bursts while stalls_on is set
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Hold the input until every predicted beat has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (payload_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_accept_id(input logic [15:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid  <= 1'b0;
        current_id = v;
    endtask

    task automatic send_record(input logic [7:0] rtype, input logic [15:0] rid,
                               input logic [15:0] clen, input logic [7:0] plen,
                               input bit retune);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(rtype);
        send_byte(rid[15:8]);
        send_byte(rid[7:0]);
        send_byte(clen[15:8]);
        send_byte(clen[7:0]);
        send_byte(plen);
        send_byte(8'($urandom_range(0, 255)));
        // new id mid-record must not affect the record already matched
        if (retune) write_accept_id(16'($urandom_range(0, 65535)));
        repeat (clen) send_byte(8'($urandom_range(0, 255)));
        repeat (plen) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic random_record();
        int          pick;
        logic [7:0]  rtype;
        logic [15:0] rid;
        logic [15:0] clen;
        logic [7:0]  plen;
        pick = $urandom_range(0, 99);
        if (pick < 35) rtype = TYPE_STDOUT;
        else if (pick < 60) rtype = TYPE_STDERR;
        else if (pick < 78) rtype = TYPE_END_REQUEST;
        else rtype = 8'($urandom_range(0, 255));
        rid  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : current_id;
        clen = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(256, 300))
                                            : 16'($urandom_range(0, 12));
        plen = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(200, 255))
                                            : 8'($urandom_range(0, 7));
        send_record(rtype, rid, clen, plen, clen != 0 && $urandom_range(0, 24) == 0);
    endtask

    initial begin
        logic [15:0] setting;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       setting = 16'h0000;
                1:       setting = 16'hFFFF;
                3:       setting = ACCEPT_ID_RESET;
                default: setting = 16'($urandom_range(0, 65535));
            endcase
            write_accept_id(setting);
            gaps_on   = (p != 1) && (p != NUM_PHASES - 1);
            stalls_on = (p != 2) && (p != NUM_PHASES - 1);
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) random_record();
        end

        settle();
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("fastcgi_response_record_deframer_top_tb: PASS");
        end else begin
            $display("fastcgi_response_record_deframer_top_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/fcgi_rd_pkg.sv
rtl/fastcgi_response_record_deframer_top.sv
tb/fcgi_rd_scoreboard.sv
tb/fastcgi_response_record_deframer_top_tb.sv
